FILE: rtl/core/mecwm_pkg.sv
package mecwm_pkg;

  // field widths
  localparam int VelW     = 16;
  localparam int LimW     = 15;
  localparam int MixW     = 18;
  localparam int MagW     = 17;
  localparam int ProdW    = MagW + LimW;
  localparam int QuotW    = 15;
  localparam int Lanes    = 4;
  localparam int DivSteps = QuotW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register reset values
  localparam logic [LimW-1:0] LimitReset      = 15'd32767;
  localparam logic [LimW-1:0] WheelLimitReset = 15'd8000;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIMIT_X     = 3'd0,
    CFG_LIMIT_Y     = 3'd1,
    CFG_LIMIT_ROT   = 3'd2,
    CFG_WHEEL_LIMIT = 3'd3
  } cfg_index_t;

  // one mixed command between front end and back end
  typedef struct packed {
    logic [Lanes-1:0][MixW-1:0] mix;
    logic [MagW-1:0]            largest;
    logic                       scale;
  } mix_item_t;

  // one stage of the scaling divider, all four wheels side by side
  typedef struct packed {
    logic [Lanes-1:0]            neg;
    logic [Lanes-1:0][VelW-1:0]  pass;
    logic [MagW-1:0]             divisor;
    logic                        scale;
    logic [Lanes-1:0][MagW-1:0]  rem;
    logic [Lanes-1:0][QuotW-1:0] quo;
  } div_stage_t;

endpackage

FILE: rtl/core/mecanum_wheel_speed_mixer.sv
// Mecanum wheel speed mixer. Each transaction on the input channel carries one
// chassis command (vel_x, vel_y, vel_rot); each component is clamped to its
// symmetric limit, mixed into the four wheel speeds x+y+w, x-y+w, -x-y+w and
// -x+y+w, and if the largest magnitude exceeds wheel_limit every wheel becomes
// value*wheel_limit/largest truncated toward zero. Exactly one output
// transaction follows each input transaction, in order. The block accepts one
// command per clock cycle when the output is not stalled; a result is offered
// once its command has passed two front-end stages, the queue, a sign stage,
// a product stage, 15 divider stages that resolve one quotient bit each, and
// then the output register. A queue of QUEUE_DEPTH commands sits between the
// mixing front end and the scaling back end. Write limits through the cfg
// channel (always ready) only while no command is in flight.
module mecanum_wheel_speed_mixer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mecwm_pkg::VelW-1:0]     vel_x,
  input  logic signed [mecwm_pkg::VelW-1:0]     vel_y,
  input  logic signed [mecwm_pkg::VelW-1:0]     vel_rot,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mecwm_pkg::VelW-1:0]     wheel_a,
  output logic signed [mecwm_pkg::VelW-1:0]     wheel_b,
  output logic signed [mecwm_pkg::VelW-1:0]     wheel_c,
  output logic signed [mecwm_pkg::VelW-1:0]     wheel_d,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [mecwm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic        [mecwm_pkg::CfgDataW-1:0] cfg_data
);

  localparam int LimW = mecwm_pkg::LimW;

  logic [LimW-1:0]      limit_x;
  logic [LimW-1:0]      limit_y;
  logic [LimW-1:0]      limit_rot;
  logic [LimW-1:0]      wheel_limit;
  logic                 push;
  mecwm_pkg::mix_item_t push_item;
  logic                 q_full;
  logic                 pop;
  mecwm_pkg::mix_item_t head;
  logic                 q_valid;

  assign cfg_ready = 1'b1;

  // configuration registers, low 15 bits kept
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_x     <= mecwm_pkg::LimitReset;
      limit_y     <= mecwm_pkg::LimitReset;
      limit_rot   <= mecwm_pkg::LimitReset;
      wheel_limit <= mecwm_pkg::WheelLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (mecwm_pkg::cfg_index_t'(cfg_index))
        mecwm_pkg::CFG_LIMIT_X:     limit_x     <= cfg_data[LimW-1:0];
        mecwm_pkg::CFG_LIMIT_Y:     limit_y     <= cfg_data[LimW-1:0];
        mecwm_pkg::CFG_LIMIT_ROT:   limit_rot   <= cfg_data[LimW-1:0];
        mecwm_pkg::CFG_WHEEL_LIMIT: wheel_limit <= cfg_data[LimW-1:0];
        default: ;
      endcase
    end
  end

  // clamp, mix and classify
  mecwm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .vel_rot     (vel_rot),
    .limit_x     (limit_x),
    .limit_y     (limit_y),
    .limit_rot   (limit_rot),
    .wheel_limit (wheel_limit),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  // decoupling queue
  mecwm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid)
  );

  // proportional scaling and output register
  mecwm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (head),
    .pop         (pop),
    .wheel_limit (wheel_limit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .wheel_a     (wheel_a),
    .wheel_b     (wheel_b),
    .wheel_c     (wheel_c),
    .wheel_d     (wheel_d)
  );

endmodule

FILE: rtl/core/mecwm_front.sv
module mecwm_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mecwm_pkg::VelW-1:0]    vel_x,
  input  logic signed [mecwm_pkg::VelW-1:0]    vel_y,
  input  logic signed [mecwm_pkg::VelW-1:0]    vel_rot,
  input  logic        [mecwm_pkg::LimW-1:0]    limit_x,
  input  logic        [mecwm_pkg::LimW-1:0]    limit_y,
  input  logic        [mecwm_pkg::LimW-1:0]    limit_rot,
  input  logic        [mecwm_pkg::LimW-1:0]    wheel_limit,
  output logic                                 push,
  output mecwm_pkg::mix_item_t                 push_item,
  input  logic                                 q_full
);

  localparam int VelW  = mecwm_pkg::VelW;
  localparam int LimW  = mecwm_pkg::LimW;
  localparam int MixW  = mecwm_pkg::MixW;
  localparam int MagW  = mecwm_pkg::MagW;
  localparam int Lanes = mecwm_pkg::Lanes;

  // symmetric clamp to [-lim, +lim]
  function automatic logic signed [VelW-1:0] clamp_sym(
    input logic signed [VelW-1:0] v,
    input logic        [LimW-1:0] lim
  );
    logic signed [VelW:0] vw;
    logic signed [VelW:0] hi;
    logic signed [VelW:0] lo;
    logic signed [VelW:0] res;
    vw = {v[VelW-1], v};
    hi = {2'b00, lim};
    lo = -hi;
    if (vw > hi) begin
      res = hi;
    end else if (vw < lo) begin
      res = lo;
    end else begin
      res = vw;
    end
    return res[VelW-1:0];
  endfunction

  logic                         front_adv;
  logic                         mix_valid;
  logic signed [MixW-1:0]       mix [Lanes];
  logic signed [VelW-1:0]       cx, cy, cw;
  logic signed [MixW-1:0]       ex, ey, ew;
  logic                         item_valid;
  mecwm_pkg::mix_item_t         item;
  logic        [MagW-1:0]       mag [Lanes];
  logic signed [MixW-1:0]       neg_mix [Lanes];
  logic        [MagW-1:0]       max01, max23, largest;

  // the front end moves when its last stage is empty or drains into the queue
  assign front_adv = !item_valid || !q_full;
  assign in_stall  = !front_adv;
  assign push      = item_valid && !q_full;
  assign push_item = item;

  // clamp and sign extend
  always_comb begin
    cx = clamp_sym(vel_x, limit_x);
    cy = clamp_sym(vel_y, limit_y);
    cw = clamp_sym(vel_rot, limit_rot);
    ex = {{(MixW-VelW){cx[VelW-1]}}, cx};
    ey = {{(MixW-VelW){cy[VelW-1]}}, cy};
    ew = {{(MixW-VelW){cw[VelW-1]}}, cw};
  end

  // stage 1: mecanum mix
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (front_adv) begin
      mix_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_adv) begin
      mix[0] <= ex + ey + ew;
      mix[1] <= ex - ey + ew;
      mix[2] <= ew - ex - ey;
      mix[3] <= ew - ex + ey;
    end
  end

  // magnitudes and the largest one
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      neg_mix[k] = -mix[k];
      mag[k]     = mix[k][MixW-1] ? neg_mix[k][MagW-1:0] : mix[k][MagW-1:0];
    end
    max01   = (mag[1] > mag[0]) ? mag[1] : mag[0];
    max23   = (mag[3] > mag[2]) ? mag[3] : mag[2];
    largest = (max23 > max01) ? max23 : max01;
  end

  // stage 2: classify, scaling needed or not
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (front_adv) begin
      item_valid <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_adv) begin
      for (int k = 0; k < Lanes; k++) begin
        item.mix[k] <= mix[k];
      end
      item.largest <= largest;
      item.scale   <= largest > {{(MagW-LimW){1'b0}}, wheel_limit};
    end
  end

endmodule

FILE: rtl/core/mecwm_queue.sv
module mecwm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mecwm_pkg::mix_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output mecwm_pkg::mix_item_t head,
  output logic                 not_empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  mecwm_pkg::mix_item_t entries [DEPTH];
  logic [PtrW-1:0]      wr_ptr;
  logic [PtrW-1:0]      rd_ptr;
  logic [CntW-1:0]      count;
  logic                 push_ok;
  logic                 pop_ok;

  assign full      = count == CntW'(DEPTH);
  assign not_empty = count != '0;
  assign push_ok   = push && !full;
  assign pop_ok    = pop && not_empty;
  assign head      = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/mecwm_back.sv
module mecwm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  mecwm_pkg::mix_item_t              q_item,
  output logic                              pop,
  input  logic [mecwm_pkg::LimW-1:0]        wheel_limit,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mecwm_pkg::VelW-1:0] wheel_a,
  output logic signed [mecwm_pkg::VelW-1:0] wheel_b,
  output logic signed [mecwm_pkg::VelW-1:0] wheel_c,
  output logic signed [mecwm_pkg::VelW-1:0] wheel_d
);

  localparam int VelW     = mecwm_pkg::VelW;
  localparam int LimW     = mecwm_pkg::LimW;
  localparam int MixW     = mecwm_pkg::MixW;
  localparam int MagW     = mecwm_pkg::MagW;
  localparam int ProdW    = mecwm_pkg::ProdW;
  localparam int QuotW    = mecwm_pkg::QuotW;
  localparam int Lanes    = mecwm_pkg::Lanes;
  localparam int DivSteps = mecwm_pkg::DivSteps;
  localparam int Stages   = DivSteps + 2;

  // one restoring division step per wheel
  function automatic mecwm_pkg::div_stage_t div_step(input mecwm_pkg::div_stage_t cur);
    mecwm_pkg::div_stage_t nxt;
    logic [MagW:0]         trial;
    logic [MagW:0]         diff;
    nxt = cur;
    for (int k = 0; k < Lanes; k++) begin
      trial = {cur.rem[k], cur.quo[k][QuotW-1]};
      diff  = trial - {1'b0, cur.divisor};
      if (trial >= {1'b0, cur.divisor}) begin
        nxt.rem[k] = diff[MagW-1:0];
        nxt.quo[k] = {cur.quo[k][QuotW-2:0], 1'b1};
      end else begin
        nxt.rem[k] = trial[MagW-1:0];
        nxt.quo[k] = {cur.quo[k][QuotW-2:0], 1'b0};
      end
    end
    return nxt;
  endfunction

  logic                          adv;
  logic [Stages-1:0]             vld;
  mecwm_pkg::div_stage_t         a_stage;
  mecwm_pkg::div_stage_t         b_stage;
  logic [Lanes-1:0][MagW-1:0]    a_mag;
  logic [MixW-1:0]               neg_mix [Lanes];
  logic [MagW-1:0]               in_mag [Lanes];
  logic [ProdW-1:0]              prod [Lanes];
  mecwm_pkg::div_stage_t         st [DivSteps+1];
  logic [VelW-1:0]               quo_ext [Lanes];
  logic [VelW-1:0]               quo_neg [Lanes];
  logic [VelW-1:0]               wheel [Lanes];

  // the whole back end holds while a finished result waits
  assign adv = !out_valid || !out_stall;
  assign pop = adv && q_valid;

  // stage valids and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[Stages-2:0], q_valid};
      out_valid <= vld[Stages-1];
    end
  end

  // magnitudes of the queue head
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      neg_mix[k] = -q_item.mix[k];
      in_mag[k]  = q_item.mix[k][MixW-1] ? neg_mix[k][MagW-1:0] : q_item.mix[k][MagW-1:0];
    end
  end

  // products of magnitude and wheel limit, loaded as divider dividends
  always_comb begin
    b_stage = a_stage;
    for (int k = 0; k < Lanes; k++) begin
      prod[k] = {{(ProdW-MagW){1'b0}}, a_mag[k]} * {{(ProdW-LimW){1'b0}}, wheel_limit};
      b_stage.rem[k] = prod[k][ProdW-1:QuotW];
      b_stage.quo[k] = prod[k][QuotW-1:0];
    end
  end

  // stage a: sign split; stage b: product; then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < Lanes; k++) begin
        a_mag[k]         <= in_mag[k];
        a_stage.neg[k]   <= q_item.mix[k][MixW-1];
        a_stage.pass[k]  <= q_item.mix[k][VelW-1:0];
        a_stage.rem[k]   <= '0;
        a_stage.quo[k]   <= '0;
      end
      a_stage.divisor <= q_item.largest;
      a_stage.scale   <= q_item.scale;

      st[0] <= b_stage;

      for (int i = 1; i <= DivSteps; i++) begin
        st[i] <= div_step(st[i-1]);
      end
    end
  end

  // sign back on, pick scaled or pass-through value
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      quo_ext[k] = {{(VelW-QuotW){1'b0}}, st[DivSteps].quo[k]};
      quo_neg[k] = -quo_ext[k];
      if (st[DivSteps].scale) begin
        wheel[k] = st[DivSteps].neg[k] ? quo_neg[k] : quo_ext[k];
      end else begin
        wheel[k] = st[DivSteps].pass[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      wheel_a <= wheel[0];
      wheel_b <= wheel[1];
      wheel_c <= wheel[2];
      wheel_d <= wheel[3];
    end
  end

endmodule

FILE: rtl/core/mecwm_checker.sv
module mecwm_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic signed [mecwm_pkg::VelW-1:0]     vel_x,
  input logic signed [mecwm_pkg::VelW-1:0]     vel_y,
  input logic signed [mecwm_pkg::VelW-1:0]     vel_rot,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [mecwm_pkg::VelW-1:0]     wheel_a,
  input logic signed [mecwm_pkg::VelW-1:0]     wheel_b,
  input logic signed [mecwm_pkg::VelW-1:0]     wheel_c,
  input logic signed [mecwm_pkg::VelW-1:0]     wheel_d,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready,
  input logic        [mecwm_pkg::CfgIdxW-1:0]  cfg_index,
  input logic        [mecwm_pkg::CfgDataW-1:0] cfg_data
);

  localparam logic [mecwm_pkg::VelW-1:0] MostNeg = {1'b1, {(mecwm_pkg::VelW-1){1'b0}}};

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its wheel values
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(wheel_a) && $stable(wheel_b) &&
                               $stable(wheel_c) && $stable(wheel_d))
    else $error("wheel values changed while stalled");

  // clamping and scaling keep every wheel within +-32767
  a_wheel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wheel_a != MostNeg && wheel_b != MostNeg &&
                  wheel_c != MostNeg && wheel_d != MostNeg)
    else $error("wheel value out of range");

  // reset empties the pipeline and frees the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind mecanum_wheel_speed_mixer mecwm_checker u_mecwm_checker (.*);
